>>> hw/rtl/amts_pkg.sv
// ----------------------------------------------------------------------------
// amts_pkg: shared types and constants of the arm/mode/takeoff sequencer
// Word layouts, configuration register map, mode codes and reset values.
// ----------------------------------------------------------------------------
package amts_pkg;

    // Register map of the configuration write channel
    typedef enum logic [2:0] {
        CFG_ARM_LEVEL        = 3'd0,
        CFG_MANUAL_BELOW     = 3'd1,
        CFG_LANDING_FROM     = 3'd2,
        CFG_THROTTLE_CEILING = 3'd3,
        CFG_HOVER_BASE       = 3'd4,
        CFG_IDLE_THROTTLE    = 3'd5,
        CFG_LIFT_ACCEL       = 3'd6
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MODE_MANUAL  = 2'd0,
        MODE_TAKEOFF = 2'd1,
        MODE_LANDING = 2'd2
    } t_mode;

    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int S_TDATA_W   = 56;
    localparam int M_TDATA_W   = 24;
    localparam int IN_W        = 52;
    localparam int RES_W       = 18;

    // Stick center band for the takeoff ramp (exclusive bounds)
    localparam logic [11:0] STICK_LOW  = 12'd1400;
    localparam logic [11:0] STICK_HIGH = 12'd1600;

    localparam logic signed [15:0] THR_MIN = -16'sd2048;
    localparam logic signed [15:0] THR_MAX = 16'sd8191;
    localparam logic signed [15:0] OFS_MIN = -16'sd2048;
    localparam logic signed [15:0] OFS_MAX = 16'sd2047;

    localparam logic [11:0]        RST_ARM_LEVEL        = 12'd1500;
    localparam logic [11:0]        RST_MANUAL_BELOW     = 12'd1200;
    localparam logic [11:0]        RST_LANDING_FROM     = 12'd1700;
    localparam logic [11:0]        RST_THROTTLE_CEILING = 12'd1750;
    localparam logic [11:0]        RST_HOVER_BASE       = 12'd1530;
    localparam logic [11:0]        RST_IDLE_THROTTLE    = 12'd1100;
    localparam logic signed [15:0] RST_LIFT_ACCEL       = 16'sd2598;
    localparam logic signed [13:0] RST_THROTTLE_LEVEL   = 14'sd1100;

    typedef struct packed {
        logic [11:0]        arm_level;
        logic [11:0]        manual_below;
        logic [11:0]        landing_from;
        logic [11:0]        throttle_ceiling;
        logic [11:0]        hover_base;
        logic [11:0]        idle_throttle;
        logic signed [15:0] lift_accel;
    } t_cfg;

    // Input word, last field in the lowest bits
    typedef struct packed {
        logic signed [15:0] accel_z;
        logic [11:0]        stick_channel;
        logic [11:0]        mode_channel;
        logic [11:0]        arm_channel;
    } t_in;

    // Result word, last field in the lowest bits
    typedef struct packed {
        logic               airborne;
        logic               motors_on;
        logic [1:0]         mode_out;
        logic signed [13:0] throttle_out;
    } t_res;

    typedef struct packed {
        logic signed [13:0] throttle_level;
        logic               airborne;
        logic signed [11:0] lift_offset;
    } t_state;

endpackage

>>> hw/rtl/arm_mode_takeoff_sequencer_unit.sv
// ----------------------------------------------------------------------------
// arm_mode_takeoff_sequencer_unit: arm, flight mode and takeoff sequencer
// Turns one control tick of RC inputs into a throttle command and status.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_axis): one word per control tick carrying the arm, mode
//   and stick pulse widths and the averaged vertical acceleration.
//   Output stream (m_axis): one result word per input word, in order:
//   throttle, flight mode, motors-on and airborne flag.
//   Configuration channel (cfg): index and data of one threshold register;
//   always ready. Write only while no word is in flight.
//   Pipeline: an accepted word passes the input register, the decision logic
//   and the result register before its result shows on m_axis.
//   Throughput: one word per cycle while m_axis is not held off; the state
//   is registered as a word enters the result register and feeds back.
//   Reset: synchronous, active low; thresholds return to defaults, throttle to
//   1100, airborne flag and offset clear, both register stages empty.
//   Stall: while m_axis is held off the result word holds, one more word is
//   kept in the input register, then s_axis tready drops.
// ----------------------------------------------------------------------------
module arm_mode_takeoff_sequencer_unit
    import amts_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // s_axis tdata: arm_channel[11:0], mode_channel[23:12], stick_channel[35:24],
    //               accel_z[51:36], zero[55:52]
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [S_TDATA_W-1:0]  i_s_axis_tdata,
    // m_axis tdata: throttle_out[13:0], mode_out[15:14], motors_on[16],
    //               airborne[17], zero[23:18]
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [M_TDATA_W-1:0]  o_m_axis_tdata,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg   w_cfg;
    t_state w_next;
    t_res   w_res;
    logic   w_adv;

    logic   r_in_vld;
    t_in    r_in;
    logic   r_out_vld;
    t_res   r_out;
    t_state r_state;

    assign o_cfg_ready = 1'b1;

    amts_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    amts_step u_step (
        .i_cfg   (w_cfg),
        .i_word  (r_in),
        .i_state (r_state),
        .o_state (w_next),
        .o_res   (w_res)
    );

    // Result register free or being drained this cycle
    assign w_adv           = !r_out_vld || i_m_axis_tready;
    assign o_s_axis_tready = !r_in_vld || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_state.throttle_level <= RST_THROTTLE_LEVEL;
            r_state.airborne       <= 1'b0;
            r_state.lift_offset    <= 12'sd0;
        end else begin
            if (o_s_axis_tready) begin
                r_in_vld <= i_s_axis_tvalid;
            end
            if (w_adv) begin
                r_out_vld <= r_in_vld;
            end
            // Advance state only when the word moves into the result register
            if (r_in_vld && w_adv) begin
                r_state <= w_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in <= t_in'(i_s_axis_tdata[IN_W-1:0]);
        end
        if (r_in_vld && w_adv) begin
            r_out <= w_res;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {{(M_TDATA_W-RES_W){1'b0}}, r_out};

endmodule

>>> hw/rtl/amts_cfg_regs.sv
// ----------------------------------------------------------------------------
// amts_cfg_regs: configuration register file
// Holds the seven thresholds; writes to unmapped indexes are dropped.
// ----------------------------------------------------------------------------
module amts_cfg_regs
    import amts_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr,
    input  logic [CFG_IDX_W-1:0]  i_index,
    input  logic [CFG_DATA_W-1:0] i_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.arm_level        <= RST_ARM_LEVEL;
            r_cfg.manual_below     <= RST_MANUAL_BELOW;
            r_cfg.landing_from     <= RST_LANDING_FROM;
            r_cfg.throttle_ceiling <= RST_THROTTLE_CEILING;
            r_cfg.hover_base       <= RST_HOVER_BASE;
            r_cfg.idle_throttle    <= RST_IDLE_THROTTLE;
            r_cfg.lift_accel       <= RST_LIFT_ACCEL;
        end else if (i_wr) begin
            unique case (t_cfg_idx'(i_index))
                CFG_ARM_LEVEL:        r_cfg.arm_level        <= i_data[11:0];
                CFG_MANUAL_BELOW:     r_cfg.manual_below     <= i_data[11:0];
                CFG_LANDING_FROM:     r_cfg.landing_from     <= i_data[11:0];
                CFG_THROTTLE_CEILING: r_cfg.throttle_ceiling <= i_data[11:0];
                CFG_HOVER_BASE:       r_cfg.hover_base       <= i_data[11:0];
                CFG_IDLE_THROTTLE:    r_cfg.idle_throttle    <= i_data[11:0];
                CFG_LIFT_ACCEL:       r_cfg.lift_accel       <= $signed(i_data);
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> hw/rtl/amts_step.sv
// ----------------------------------------------------------------------------
// amts_step: per-tick decision logic
// Derives arm state and flight mode, then the next throttle, offset and flag.
// ----------------------------------------------------------------------------
module amts_step
    import amts_pkg::*;
(
    input  t_cfg   i_cfg,
    input  t_in    i_word,
    input  t_state i_state,
    output t_state o_state,
    output t_res   o_res
);

    function automatic logic signed [15:0] sat_thr(input logic signed [15:0] v);
        logic signed [15:0] r;
        r = v;
        if (v < THR_MIN) r = THR_MIN;
        if (v > THR_MAX) r = THR_MAX;
        return r;
    endfunction

    function automatic logic signed [11:0] sat_ofs(input logic signed [15:0] v);
        logic signed [11:0] r;
        r = v[11:0];
        if (v < OFS_MIN) r = OFS_MIN[11:0];
        if (v > OFS_MAX) r = OFS_MAX[11:0];
        return r;
    endfunction

    always_comb begin
        logic               v_motors;
        logic               v_af;
        logic signed [11:0] v_ofs;
        logic signed [15:0] v_thr;
        logic signed [15:0] v_diff;
        logic signed [15:0] v_sum;
        logic signed [15:0] v_ceil;
        logic signed [15:0] v_hover;
        logic signed [15:0] v_idle;
        logic signed [15:0] v_stick;
        t_mode              v_mode;

        v_motors = i_word.arm_channel > i_cfg.arm_level;
        // Disarm clears the flag and the offset; throttle holds
        v_af     = i_state.airborne & v_motors;
        v_ofs    = v_motors ? i_state.lift_offset : 12'sd0;
        v_thr    = {{2{i_state.throttle_level[13]}}, i_state.throttle_level};
        v_ceil   = $signed({4'b0, i_cfg.throttle_ceiling});
        v_hover  = $signed({4'b0, i_cfg.hover_base});
        v_idle   = $signed({4'b0, i_cfg.idle_throttle});
        v_stick  = $signed({4'b0, i_word.stick_channel});
        v_diff   = '0;
        v_sum    = '0;

        // Mode channel equal to manual_below counts as takeoff
        if (i_word.mode_channel < i_cfg.manual_below) begin
            v_mode = MODE_MANUAL;
        end else if (i_word.mode_channel < i_cfg.landing_from) begin
            v_mode = MODE_TAKEOFF;
        end else begin
            v_mode = MODE_LANDING;
        end

        if (v_motors) begin
            unique case (v_mode)
                MODE_MANUAL: begin
                    v_thr = v_stick;
                end
                MODE_TAKEOFF: begin
                    if (!v_af && i_word.stick_channel > STICK_LOW &&
                        i_word.stick_channel < STICK_HIGH) begin
                        v_thr = sat_thr(v_thr + 16'sd1);
                        if (v_thr >= v_ceil) begin
                            v_thr = v_ceil;
                            v_ofs = 12'sd0;
                        end
                        if (i_word.accel_z > i_cfg.lift_accel) begin
                            v_af   = 1'b1;
                            v_diff = v_thr - v_hover;
                            v_ofs  = sat_ofs(v_diff);
                        end
                    end
                    // After liftoff, including the liftoff tick itself
                    if (v_af) begin
                        v_sum = v_stick + {{4{v_ofs[11]}}, v_ofs};
                        v_thr = sat_thr(v_sum);
                    end
                end
                MODE_LANDING: begin
                    if (v_af) begin
                        if (v_thr > v_idle) v_thr = v_thr - 16'sd1;
                        if (v_thr <= v_idle) v_af = 1'b0;
                    end
                end
                default: ;
            endcase
        end

        o_state.throttle_level = v_thr[13:0];
        o_state.airborne       = v_af;
        o_state.lift_offset    = v_ofs;

        o_res.throttle_out = v_thr[13:0];
        o_res.mode_out     = v_mode;
        o_res.motors_on    = v_motors;
        o_res.airborne     = v_af;
    end

endmodule

>>> hw/rtl/amts_checker.sv
// ----------------------------------------------------------------------------
// amts_checker: port-level checks of the sequencer
// Watches the result stream for stall behavior and consistent status fields.
// ----------------------------------------------------------------------------
module amts_checker
    import amts_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_m_axis_tvalid,
    input logic                 i_m_axis_tready,
    input logic [M_TDATA_W-1:0] o_m_axis_tdata
);

    // A stalled result word holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result word changed under stall");

    // Reset empties the result stage
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    // Airborne only while armed
    a_air_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !(o_m_axis_tdata[17] && !o_m_axis_tdata[16]))
        else $error("airborne reported while disarmed");

    // Mode code in range, throttle never below -2048
    a_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[15:14] != 2'd3) &&
            !(o_m_axis_tdata[13] && !(o_m_axis_tdata[12] && o_m_axis_tdata[11])))
        else $error("result field out of range");

endmodule

bind arm_mode_takeoff_sequencer_unit amts_checker u_amts_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
